[rtl/fbmp_pkg.sv]
package fbmp_pkg;

    // Field widths of the beats and of the configuration register.
    localparam int BLK_W   = 32;
    localparam int SIZE_W  = 48;
    localparam int SHIFT_W = 5;
    localparam int K_W     = 4;
    localparam int IDX_W   = 14;
    localparam int SLOT_W  = 4;
    localparam int DEPTH_W = 2;

    // Legal range of the block size shift and its value after reset.
    localparam logic [SHIFT_W-1:0] SHIFT_MIN   = 5'd10;
    localparam logic [SHIFT_W-1:0] SHIFT_MAX   = 5'd16;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd10;

    // Log2 of the bytes in one block pointer.
    localparam logic [SHIFT_W-1:0] PTR_SHIFT = 5'd2;

    // Mapping depth codes.
    localparam logic [DEPTH_W-1:0] DEPTH_DIRECT = 2'd0;
    localparam logic [DEPTH_W-1:0] DEPTH_SINGLE = 2'd1;
    localparam logic [DEPTH_W-1:0] DEPTH_DOUBLE = 2'd2;
    localparam logic [DEPTH_W-1:0] DEPTH_TRIPLE = 2'd3;

    // Input beat, logical block in the low bits.
    typedef struct packed {
        logic [SIZE_W-1:0] file_size;
        logic [BLK_W-1:0]  logical_block;
    } item_t;

    // Mapping path, depth in the low bits.
    typedef struct packed {
        logic [IDX_W-1:0]   third_index;
        logic [IDX_W-1:0]   second_index;
        logic [IDX_W-1:0]   first_index;
        logic [SLOT_W-1:0]  root_slot;
        logic [DEPTH_W-1:0] depth;
    } map_t;

    // Complete result beat.
    typedef struct packed {
        logic error;
        map_t path;
    } result_t;

endpackage

[rtl/fbmp_pipe.sv]
module fbmp_pipe #(
    parameter int DIRECT_SLOTS = 12
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [fbmp_pkg::SHIFT_W-1:0]  eff_shift,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  fbmp_pkg::item_t               in_item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output fbmp_pkg::result_t             out_result
);
    import fbmp_pkg::*;

    localparam int SHAMT_W = 6;

    // Pointer-per-block exponent and its multiples.
    logic [K_W-1:0]     k;
    logic [SHAMT_W-1:0] k2;
    logic [SHAMT_W-1:0] k3;
    logic [IDX_W-1:0]   idx_mask;

    assign k        = K_W'(eff_shift - PTR_SHIFT);
    assign k2       = SHAMT_W'(k) << 1;
    assign k3       = SHAMT_W'(k) + k2;
    assign idx_mask = ~({IDX_W{1'b1}} << k);

    // Per-stage flow control: a stage loads when it is empty or drains.
    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic s3_valid_reg, s3_valid_next;
    logic s2_ready, s3_ready;

    assign s3_ready = !s3_valid_reg || out_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign in_ready = !s1_valid_reg || s2_ready;

    assign s1_valid_next = in_ready ? in_valid : s1_valid_reg;
    assign s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;
    assign s3_valid_next = s3_ready ? s2_valid_reg : s3_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    // Stage 1: end-of-file check and offset past the direct slots.
    // The block is inside the file exactly when its first byte lies below the size.
    logic [SIZE_W-1:0] blk_bytes;
    logic              s1_eof_next, s1_eof_reg;
    logic              s1_direct_next, s1_direct_reg;
    logic [SLOT_W-1:0] s1_slot_reg;
    logic [BLK_W-1:0]  s1_rem_next, s1_rem_reg;

    assign blk_bytes      = SIZE_W'(in_item.logical_block) << eff_shift;
    assign s1_eof_next    = blk_bytes >= in_item.file_size;
    assign s1_direct_next = in_item.logical_block < BLK_W'(DIRECT_SLOTS);
    assign s1_rem_next    = in_item.logical_block - BLK_W'(DIRECT_SLOTS);

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            s1_eof_reg    <= s1_eof_next;
            s1_direct_reg <= s1_direct_next;
            s1_slot_reg   <= in_item.logical_block[SLOT_W-1:0];
            s1_rem_reg    <= s1_rem_next;
        end
    end

    // Stage 2: pick the indirection level and the offset within that level.
    // The two level capacities are distinct powers of two, so their sum is an OR.
    logic [BLK_W-1:0]   cap1, cap2;
    logic [BLK_W-1:0]   rem2, rem3;
    logic               lt1, lt2, lt3;
    logic               s2_err_next, s2_err_reg;
    logic [DEPTH_W-1:0] s2_depth_next, s2_depth_reg;
    logic [BLK_W-1:0]   s2_val_next, s2_val_reg;
    logic [SLOT_W-1:0]  s2_slot_reg;

    assign cap1 = BLK_W'(1) << k;
    assign cap2 = BLK_W'(1) << k2;
    assign rem2 = s1_rem_reg - cap1;
    assign rem3 = s1_rem_reg - (cap1 | cap2);
    assign lt1  = (s1_rem_reg >> k) == '0;
    assign lt2  = (rem2 >> k2) == '0;
    assign lt3  = (k3 >= SHAMT_W'(BLK_W)) || ((rem3 >> k3) == '0);

    always_comb begin
        s2_err_next   = s1_eof_reg;
        s2_depth_next = DEPTH_DIRECT;
        s2_val_next   = s1_rem_reg;
        if (!s1_direct_reg) begin
            if (lt1) begin
                s2_depth_next = DEPTH_SINGLE;
            end else if (lt2) begin
                s2_depth_next = DEPTH_DOUBLE;
                s2_val_next   = rem2;
            end else begin
                s2_depth_next = DEPTH_TRIPLE;
                s2_val_next   = rem3;
                if (!lt3) begin
                    s2_err_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_ready && s1_valid_reg) begin
            s2_err_reg   <= s2_err_next;
            s2_depth_reg <= s2_depth_next;
            s2_val_reg   <= s2_val_next;
            s2_slot_reg  <= s1_slot_reg;
        end
    end

    // Stage 3: split the offset into per-level indices and form the result.
    result_t s3_res_next, s3_res_reg;

    always_comb begin
        s3_res_next       = '0;
        s3_res_next.error = s2_err_reg;
        if (!s2_err_reg) begin
            s3_res_next.path.depth = s2_depth_reg;
            case (s2_depth_reg)
                DEPTH_DIRECT: begin
                    s3_res_next.path.root_slot = s2_slot_reg;
                end
                DEPTH_SINGLE: begin
                    s3_res_next.path.first_index = IDX_W'(s2_val_reg) & idx_mask;
                end
                DEPTH_DOUBLE: begin
                    s3_res_next.path.first_index  = IDX_W'(s2_val_reg >> k) & idx_mask;
                    s3_res_next.path.second_index = IDX_W'(s2_val_reg) & idx_mask;
                end
                DEPTH_TRIPLE: begin
                    s3_res_next.path.first_index  = IDX_W'(s2_val_reg >> k2) & idx_mask;
                    s3_res_next.path.second_index = IDX_W'(s2_val_reg >> k) & idx_mask;
                    s3_res_next.path.third_index  = IDX_W'(s2_val_reg) & idx_mask;
                end
                default: begin
                    s3_res_next.path.root_slot = s2_slot_reg;
                end
            endcase
            if (s2_depth_reg != DEPTH_DIRECT) begin
                s3_res_next.path.root_slot = SLOT_W'(DIRECT_SLOTS - 1)
                                           + SLOT_W'(s2_depth_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s3_ready && s2_valid_reg) begin
            s3_res_reg <= s3_res_next;
        end
    end

    assign out_valid  = s3_valid_reg;
    assign out_result = s3_res_reg;

    // An error result carries an all-zero path.
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && out_result.error |-> out_result.path == '0)
        else $error("error result with nonzero path");

    // A direct block names a slot inside the direct range.
    a_direct_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && !out_result.error && out_result.path.depth == DEPTH_DIRECT
        |-> out_result.path.root_slot < SLOT_W'(DIRECT_SLOTS))
        else $error("direct slot out of range");

    // An indirect block uses the root slot that belongs to its depth.
    a_indirect_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && !out_result.error && out_result.path.depth != DEPTH_DIRECT
        |-> out_result.path.root_slot
            == SLOT_W'(DIRECT_SLOTS - 1) + SLOT_W'(out_result.path.depth))
        else $error("root slot does not match depth");

    // The first index always fits in one pointer block.
    a_first_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> (out_result.path.first_index >> k) == '0)
        else $error("first index beyond pointers per block");

    // A middle-stage beat is held while the stage ahead stays full.
    a_s2_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s2_valid_reg && !s3_ready |=> s2_valid_reg)
        else $error("stage 2 beat dropped under stall");

endmodule

[rtl/file_block_map_path.sv]
// Channel   Direction  Contents
// s_axis    in         tdata: logical_block, file_size (80 bits)
// m_axis    out        tdata: path (48 bits), tuser: error
// cfg       in         block_size_shift write, no read-back
//
// One beat is accepted per cycle while no stall on m_tready holds the input
// stage; each beat passes through the three register stages of fbmp_pipe.
// aresetn is synchronous and active low; it empties the pipeline and sets
// block_size_shift to 10. A stall on m_tready holds each full stage with no
// empty stage after it, while empty stages keep accepting beats.
module file_block_map_path #(
    parameter int DIRECT_SLOTS = 12
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration write.
    input  logic                          cfg_wr_en,
    input  logic [fbmp_pkg::SHIFT_W-1:0]  cfg_wr_data,
    // Input beat.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [79:0]                   s_tdata,   // logical_block, file_size
    // Result beat.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [47:0]                   m_tdata,   // depth, root_slot, first_index,
                                                     // second_index, third_index
    output logic                          m_tuser    // error
);
    import fbmp_pkg::*;

    // Block size shift register, kept as written.
    logic [SHIFT_W-1:0] shift_reg;
    logic [SHIFT_W-1:0] eff_shift;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg <= SHIFT_RESET;
        end else if (cfg_wr_en) begin
            shift_reg <= cfg_wr_data;
        end
    end

    // Saturate the shift to the supported block sizes.
    always_comb begin
        if (shift_reg < SHIFT_MIN) begin
            eff_shift = SHIFT_MIN;
        end else if (shift_reg > SHIFT_MAX) begin
            eff_shift = SHIFT_MAX;
        end else begin
            eff_shift = shift_reg;
        end
    end

    // Mapping pipeline.
    item_t   in_item;
    result_t out_result;

    assign in_item = item_t'(s_tdata);

    fbmp_pipe #(
        .DIRECT_SLOTS (DIRECT_SLOTS)
    ) u_pipe (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .eff_shift  (eff_shift),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (out_result)
    );

    assign m_tdata = out_result.path;
    assign m_tuser = out_result.error;

endmodule
